// ===== src/i2c_ra_pkg.sv =====
package i2c_ra_pkg;

	typedef enum logic [15:0] {
		ST_IDLE     = 16'h0001,
		ST_START_A  = 16'h0002,
		ST_START_B  = 16'h0004,
		ST_WBIT_LO  = 16'h0008,
		ST_WBIT_HI  = 16'h0010,
		ST_ACK_LO   = 16'h0020,
		ST_ACK_HI   = 16'h0040,
		ST_ACK_END  = 16'h0080,
		ST_RBIT_LO  = 16'h0100,
		ST_RBIT_HI  = 16'h0200,
		ST_NACK_LO  = 16'h0400,
		ST_NACK_HI  = 16'h0800,
		ST_NACK_END = 16'h1000,
		ST_STOP_A   = 16'h2000,
		ST_STOP_B   = 16'h4000,
		ST_STOP_C   = 16'h8000
	} step_t;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		logic scl;
		logic sda;
	} lines_t;

	localparam logic [1:0] STAGE_SLAVE = 2'd0;
	localparam logic [1:0] STAGE_REG   = 2'd1;
	localparam logic [1:0] STAGE_THIRD = 2'd2;
	localparam logic [1:0] STAGE_READ  = 2'd3;
	localparam logic [2:0] LAST_BIT    = 3'd7;

	function automatic lines_t step_lines(input step_t step);
		lines_t l;
		l = '{scl: 1'b1, sda: 1'b1};
		unique case (step)
			ST_IDLE:     l = '{scl: 1'b1, sda: 1'b1};
			ST_START_A:  l = '{scl: 1'b1, sda: 1'b1};
			ST_START_B:  l = '{scl: 1'b1, sda: 1'b0};
			ST_WBIT_LO:  l = '{scl: 1'b0, sda: 1'b0};
			ST_WBIT_HI:  l = '{scl: 1'b1, sda: 1'b0};
			ST_ACK_LO:   l = '{scl: 1'b0, sda: 1'b1};
			ST_ACK_HI:   l = '{scl: 1'b1, sda: 1'b1};
			ST_ACK_END:  l = '{scl: 1'b0, sda: 1'b1};
			ST_RBIT_LO:  l = '{scl: 1'b0, sda: 1'b1};
			ST_RBIT_HI:  l = '{scl: 1'b1, sda: 1'b1};
			ST_NACK_LO:  l = '{scl: 1'b0, sda: 1'b1};
			ST_NACK_HI:  l = '{scl: 1'b1, sda: 1'b1};
			ST_NACK_END: l = '{scl: 1'b0, sda: 1'b1};
			ST_STOP_A:   l = '{scl: 1'b0, sda: 1'b0};
			ST_STOP_B:   l = '{scl: 1'b1, sda: 1'b0};
			ST_STOP_C:   l = '{scl: 1'b1, sda: 1'b1};
			default:     l = '{scl: 1'b1, sda: 1'b1};
		endcase
		return l;
	endfunction

endpackage

// ===== src/i2c_register_access_master.sv =====
// channel   | dir | handshake                     | contents
// s_axis    | in  | s_axis_tvalid / s_axis_tready | one tick: sampled sda and optional command
// m_axis    | out | m_axis_tvalid / m_axis_tready | line drive and status for that tick
// cfg       | in  | cfg_valid / cfg_ready         | phase length in ticks
//
// one request per clock while m_axis is not stalled; the bus sequencer advances at most one line phase per request
// and its next state is computed in one pass from the request and the state registers
// a single output register holds the result; a new request is taken while it drains
// reset (arst_n low) returns the sequencer to idle and the phase length to one tick
// a stall on m_axis holds the output and stops intake until it is taken
module i2c_register_access_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // slave_addr, reg_addr, write_data, sda_in, zero pad
	input  logic [1:0]  s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // scl_line, sda_drive, busy_res, done_res, read_data, pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	i2c_ra_pkg::step_t step_q, step_d, step_c;
	logic [1:0]  stage_q, stage_d;
	logic [2:0]  bit_cnt_q, bit_cnt_d;
	logic [7:0]  shift_q, shift_d;
	logic [7:0]  slave_q, slave_d;
	logic [7:0]  reg_q, reg_d;
	logic [7:0]  data_q, data_d;
	logic        is_read_q, is_read_d;
	logic [15:0] timer_q, timer_d;
	logic [7:0]  last_read_q, last_read_d;
	logic [15:0] phase_ticks_q;
	logic        m_valid_q;
	logic [15:0] m_data_q;

	logic [7:0]  slave_addr, reg_addr, write_data;
	logic        sda_in;
	i2c_ra_pkg::op_t op;
	logic        accept, cmd, busy, done, scl, sda;
	logic [15:0] len;
	logic [16:0] timer_inc;
	i2c_ra_pkg::lines_t lines;

	assign slave_addr = s_axis_tdata[7:0];
	assign reg_addr   = s_axis_tdata[15:8];
	assign write_data = s_axis_tdata[23:16];
	assign sda_in     = s_axis_tdata[24];
	assign op         = i2c_ra_pkg::op_t'(s_axis_tuser);

	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	assign len       = (phase_ticks_q == 16'd0) ? 16'd1 : phase_ticks_q;
	assign cmd       = (step_q == i2c_ra_pkg::ST_IDLE)
	                   && (op == i2c_ra_pkg::OP_WRITE || op == i2c_ra_pkg::OP_READ);
	assign step_c    = cmd ? i2c_ra_pkg::ST_START_A : step_q;
	assign lines     = i2c_ra_pkg::step_lines(step_c);
	assign busy      = (step_c != i2c_ra_pkg::ST_IDLE);

	always_comb begin
		stage_d     = stage_q;
		bit_cnt_d   = bit_cnt_q;
		shift_d     = shift_q;
		slave_d     = slave_q;
		reg_d       = reg_q;
		data_d      = data_q;
		is_read_d   = is_read_q;
		timer_d     = timer_q;
		last_read_d = last_read_q;
		done        = 1'b0;

		// command latch, first tick of start
		if (cmd) begin
			slave_d   = slave_addr;
			reg_d     = reg_addr;
			data_d    = write_data;
			is_read_d = (op == i2c_ra_pkg::OP_READ);
			bit_cnt_d = 3'd0;
			shift_d   = 8'd0;
			stage_d   = i2c_ra_pkg::STAGE_SLAVE;
			timer_d   = 16'd0;
		end
		step_d = step_c;

		scl = lines.scl;
		sda = lines.sda;
		if (step_c == i2c_ra_pkg::ST_WBIT_LO || step_c == i2c_ra_pkg::ST_WBIT_HI) begin
			sda = shift_d[7];
		end

		timer_inc = {1'b0, timer_d} + 17'd1;

		if (busy) begin
			if (timer_inc < {1'b0, len}) begin
				timer_d = timer_inc[15:0];
			end else if (step_c == i2c_ra_pkg::ST_ACK_HI && sda_in) begin
				timer_d = len - 16'd1;
			end else begin
				timer_d = 16'd0;
				unique case (step_c)
					i2c_ra_pkg::ST_START_A: step_d = i2c_ra_pkg::ST_START_B;
					i2c_ra_pkg::ST_START_B: begin
						shift_d   = (stage_d == i2c_ra_pkg::STAGE_SLAVE) ? slave_d
						            : (slave_d | 8'h01);
						bit_cnt_d = 3'd0;
						step_d    = i2c_ra_pkg::ST_WBIT_LO;
					end
					i2c_ra_pkg::ST_WBIT_LO: step_d = i2c_ra_pkg::ST_WBIT_HI;
					i2c_ra_pkg::ST_WBIT_HI: begin
						shift_d = {shift_d[6:0], 1'b0};
						if (bit_cnt_d == i2c_ra_pkg::LAST_BIT) begin
							bit_cnt_d = 3'd0;
							step_d    = i2c_ra_pkg::ST_ACK_LO;
						end else begin
							bit_cnt_d = bit_cnt_d + 3'd1;
							step_d    = i2c_ra_pkg::ST_WBIT_LO;
						end
					end
					i2c_ra_pkg::ST_ACK_LO: step_d = i2c_ra_pkg::ST_ACK_HI;
					i2c_ra_pkg::ST_ACK_HI: step_d = i2c_ra_pkg::ST_ACK_END;
					i2c_ra_pkg::ST_ACK_END: begin
						if (stage_d == i2c_ra_pkg::STAGE_SLAVE) begin
							shift_d   = reg_d;
							bit_cnt_d = 3'd0;
							stage_d   = i2c_ra_pkg::STAGE_REG;
							step_d    = i2c_ra_pkg::ST_WBIT_LO;
						end else if (stage_d == i2c_ra_pkg::STAGE_REG) begin
							stage_d = i2c_ra_pkg::STAGE_THIRD;
							if (is_read_d) begin
								step_d = i2c_ra_pkg::ST_START_A;
							end else begin
								shift_d   = data_d;
								bit_cnt_d = 3'd0;
								step_d    = i2c_ra_pkg::ST_WBIT_LO;
							end
						end else if (stage_d == i2c_ra_pkg::STAGE_THIRD && is_read_d) begin
							shift_d   = 8'd0;
							bit_cnt_d = 3'd0;
							stage_d   = i2c_ra_pkg::STAGE_READ;
							step_d    = i2c_ra_pkg::ST_RBIT_LO;
						end else begin
							step_d = i2c_ra_pkg::ST_STOP_A;
						end
					end
					i2c_ra_pkg::ST_RBIT_LO: step_d = i2c_ra_pkg::ST_RBIT_HI;
					i2c_ra_pkg::ST_RBIT_HI: begin
						shift_d = {shift_d[6:0], sda_in};
						if (bit_cnt_d == i2c_ra_pkg::LAST_BIT) begin
							bit_cnt_d   = 3'd0;
							last_read_d = shift_d;
							step_d      = i2c_ra_pkg::ST_NACK_LO;
						end else begin
							bit_cnt_d = bit_cnt_d + 3'd1;
							step_d    = i2c_ra_pkg::ST_RBIT_LO;
						end
					end
					i2c_ra_pkg::ST_NACK_LO:  step_d = i2c_ra_pkg::ST_NACK_HI;
					i2c_ra_pkg::ST_NACK_HI:  step_d = i2c_ra_pkg::ST_NACK_END;
					i2c_ra_pkg::ST_NACK_END: step_d = i2c_ra_pkg::ST_STOP_A;
					i2c_ra_pkg::ST_STOP_A:   step_d = i2c_ra_pkg::ST_STOP_B;
					i2c_ra_pkg::ST_STOP_B:   step_d = i2c_ra_pkg::ST_STOP_C;
					i2c_ra_pkg::ST_STOP_C: begin
						step_d    = i2c_ra_pkg::ST_IDLE;
						stage_d   = i2c_ra_pkg::STAGE_SLAVE;
						bit_cnt_d = 3'd0;
						done      = 1'b1;
					end
					default: begin
						step_d  = i2c_ra_pkg::ST_IDLE;
						stage_d = i2c_ra_pkg::STAGE_SLAVE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q        <= i2c_ra_pkg::ST_IDLE;
			stage_q       <= 2'd0;
			bit_cnt_q     <= 3'd0;
			shift_q       <= 8'd0;
			slave_q       <= 8'd0;
			reg_q         <= 8'd0;
			data_q        <= 8'd0;
			is_read_q     <= 1'b0;
			timer_q       <= 16'd0;
			last_read_q   <= 8'd0;
			phase_ticks_q <= 16'd1;
			m_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				phase_ticks_q <= cfg_data;
			end
			if (accept) begin
				step_q      <= step_d;
				stage_q     <= stage_d;
				bit_cnt_q   <= bit_cnt_d;
				shift_q     <= shift_d;
				slave_q     <= slave_d;
				reg_q       <= reg_d;
				data_q      <= data_d;
				is_read_q   <= is_read_d;
				timer_q     <= timer_d;
				last_read_q <= last_read_d;
				m_valid_q   <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= {4'd0, last_read_d, done, busy, sda, scl};
		end
	end

	// stop completes only inside a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_data_q[3] |-> m_data_q[2])
		else $error("done reported without busy");

	// idle sequencer keeps a cleared phase timer
	assert property (@(posedge clk) disable iff (!arst_n)
		step_q == i2c_ra_pkg::ST_IDLE |-> timer_q == 16'd0 && stage_q == 2'd0)
		else $error("idle with stale timer or stage");

	// bit counter is back at zero during acknowledge phases
	assert property (@(posedge clk) disable iff (!arst_n)
		step_q == i2c_ra_pkg::ST_ACK_LO || step_q == i2c_ra_pkg::ST_ACK_HI
		|| step_q == i2c_ra_pkg::ST_ACK_END || step_q == i2c_ra_pkg::ST_NACK_LO
		|-> bit_cnt_q == 3'd0)
		else $error("bit counter not cleared at acknowledge");

	// state only moves on an accepted request
	assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(step_q) && $stable(timer_q))
		else $error("sequencer moved without a request");

endmodule
